/* sv/caldc_pkg.sv */
// Package for the calendar date counter: operation codes, date and item types,
// calendar constants and the month length function.
// No dependencies; every other file of the block imports it.
package caldc_pkg;

    typedef enum logic [2:0] {
        OP_LOAD     = 3'd0,
        OP_SET_DAY  = 3'd1,
        OP_SET_MON  = 3'd2,
        OP_SET_YEAR = 3'd3,
        OP_NEXT_DAY = 3'd4,
        OP_PREV_DAY = 3'd5
    } t_op;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_date;

    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAYS_28 = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_29 = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_30 = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_31 = 5'd31;

    // Multiplicative inverse of 25 modulo 2**14. A year is a multiple of 25
    // exactly when year * INV25 (mod 2**14) is at most DIV25_MAX.
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (month == MONTH_FEB) begin
            len = leap ? DAYS_29 : DAYS_28;
        end else if (month == MONTH_APR || month == MONTH_JUN ||
                     month == MONTH_SEP || month == MONTH_NOV) begin
            len = DAYS_30;
        end else begin
            len = DAYS_31;
        end
        return len;
    endfunction

endpackage

/* sv/caldc_if.sv */
// Valid/ready channel interfaces for the calendar date counter: one for
// command beats and one for result beats. Depends on caldc_pkg.
interface caldc_in_if;
    import caldc_pkg::*;

    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [DAY_W-1:0]   new_day;
    logic [MONTH_W-1:0] new_month;
    logic [YEAR_W-1:0]  new_year;

    modport source (output valid, output operation, output new_day,
                    output new_month, output new_year, input ready);
    modport sink   (input valid, input operation, input new_day,
                    input new_month, input new_year, output ready);
endinterface

interface caldc_out_if;
    import caldc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   day_now;
    logic [MONTH_W-1:0] month_now;
    logic [YEAR_W-1:0]  year_now;
    logic               status;

    modport source (output valid, output day_now, output month_now,
                    output year_now, output status, input ready);
    modport sink   (input valid, input day_now, input month_now,
                    input year_now, input status, output ready);
endinterface

/* sv/calendar_date_counter.sv */
// Top level of the calendar date counter: input register, date state and
// result register. Depends on caldc_pkg, caldc_if, caldc_update.
//
// Usage:
//   Command beats arrive on i_in (operation, new_day, new_month, new_year) and
//   each one yields exactly one result beat on o_out (day_now, month_now,
//   year_now, status), in order. Status 1 marks a load or set that would give
//   an invalid date; the stored date is then left as it was.
//   A beat is taken at a rising edge with valid and ready both high.
//   A taken command waits in the input register; its result enters the
//   result register and shows on o_out at the edge where the stored date changes.
//   Throughput: one command per cycle while o_out.ready stays high; the input
//   register and the result register advance together, and the date update
//   is one pass of logic between them with the date registers fed back.
//   When the receiver holds o_out.ready low, the result register holds, the
//   input register fills, and i_in.ready drops until the result is taken.
//   Reset (i_rst_n low at a clock edge) empties both registers and sets the
//   stored date to day 1, month 1, year 2000.
module calendar_date_counter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    caldc_in_if.sink   i_in,
    caldc_out_if.source o_out
);
    import caldc_pkg::*;

    logic               r_in_valid;
    logic [2:0]         r_operation;
    logic [DAY_W-1:0]   r_new_day;
    logic [MONTH_W-1:0] r_new_month;
    logic [YEAR_W-1:0]  r_new_year;

    t_date              r_date;
    t_date              n_date;
    logic               n_status;

    logic               r_out_valid;
    t_date              r_out_date;
    logic               r_out_status;

    logic               w_out_free;
    logic               w_advance;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_out_free;

    caldc_update u_update (
        .i_cur       (r_date),
        .i_operation (r_operation),
        .i_new_day   (r_new_day),
        .i_new_month (r_new_month),
        .i_new_year  (r_new_year),
        .o_next      (n_date),
        .o_status    (n_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_date      <= '{day: RESET_DAY, month: RESET_MONTH, year: RESET_YEAR};
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_advance) begin
                r_date <= n_date;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_operation <= i_in.operation;
            r_new_day   <= i_in.new_day;
            r_new_month <= i_in.new_month;
            r_new_year  <= i_in.new_year;
        end
        if (w_advance) begin
            r_out_date   <= n_date;
            r_out_status <= n_status;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.day_now   = r_out_date.day;
    assign o_out.month_now = r_out_date.month;
    assign o_out.year_now  = r_out_date.year;
    assign o_out.status    = r_out_status;

endmodule

/* sv/caldc_leap.sv */
// Gregorian leap year test for a year of up to 14 bits.
// Depends on caldc_pkg.
module caldc_leap (
    input  logic [caldc_pkg::YEAR_W-1:0] i_year,
    output logic                         o_leap
);
    import caldc_pkg::*;

    logic [YEAR_W-1:0] w_prod;
    logic              w_div4;
    logic              w_div16;
    logic              w_div25;

    // Divisible by 100 is divisible by 4 and by 25; by 400 is by 16 and by 25.
    // Only the low bits of the product matter, so it is kept modulo 2**14.
    assign w_prod  = i_year * INV25;
    assign w_div25 = (w_prod <= DIV25_MAX);
    assign w_div4  = (i_year[1:0] == 2'b00);
    assign w_div16 = (i_year[3:0] == 4'b0000);
    assign o_leap  = w_div4 && (!w_div25 || w_div16);

endmodule

/* sv/caldc_update.sv */
// Next-state logic of the calendar date counter: loads and sets with their
// validity check, and day steps forward and back. Depends on caldc_pkg, caldc_leap.
module caldc_update (
    input  caldc_pkg::t_date                 i_cur,
    input  logic [2:0]                       i_operation,
    input  logic [caldc_pkg::DAY_W-1:0]      i_new_day,
    input  logic [caldc_pkg::MONTH_W-1:0]    i_new_month,
    input  logic [caldc_pkg::YEAR_W-1:0]     i_new_year,
    output caldc_pkg::t_date                 o_next,
    output logic                             o_status
);
    import caldc_pkg::*;

    logic             w_cur_leap;
    logic             w_new_leap;
    t_date            w_cand;
    logic             w_cand_leap;
    logic             w_cand_ok;
    logic [DAY_W-1:0] w_cur_len;
    logic [DAY_W-1:0] w_prev_len;
    logic [MONTH_W-1:0] w_prev_month;

    caldc_leap u_cur_leap (.i_year(i_cur.year), .o_leap(w_cur_leap));
    caldc_leap u_new_leap (.i_year(i_new_year), .o_leap(w_new_leap));

    assign w_cur_len    = month_len(i_cur.month, w_cur_leap);
    assign w_prev_month = i_cur.month - 4'd1;
    assign w_prev_len   = month_len(w_prev_month, w_cur_leap);

    // Candidate date for a load or set: new fields over the stored ones.
    always_comb begin
        w_cand      = i_cur;
        w_cand_leap = w_cur_leap;
        case (i_operation)
            OP_LOAD: begin
                w_cand.day   = i_new_day;
                w_cand.month = i_new_month;
                w_cand.year  = i_new_year;
                w_cand_leap  = w_new_leap;
            end
            OP_SET_DAY: begin
                w_cand.day = i_new_day;
            end
            OP_SET_MON: begin
                w_cand.month = i_new_month;
            end
            OP_SET_YEAR: begin
                w_cand.year = i_new_year;
                w_cand_leap = w_new_leap;
            end
            default: begin
                w_cand      = i_cur;
                w_cand_leap = w_cur_leap;
            end
        endcase
    end

    assign w_cand_ok = (w_cand.month >= MONTH_JAN) && (w_cand.month <= MONTH_DEC) &&
                       (w_cand.year <= YEAR_MAX) && (w_cand.day != '0) &&
                       (w_cand.day <= month_len(w_cand.month, w_cand_leap));

    always_comb begin
        o_next   = i_cur;
        o_status = 1'b0;
        case (i_operation) inside
            OP_LOAD, OP_SET_DAY, OP_SET_MON, OP_SET_YEAR: begin
                if (w_cand_ok) begin
                    o_next = w_cand;
                end else begin
                    o_status = 1'b1;
                end
            end
            OP_NEXT_DAY: begin
                if (i_cur.day >= w_cur_len) begin
                    o_next.day = RESET_DAY;
                    if (i_cur.month >= MONTH_DEC) begin
                        o_next.month = MONTH_JAN;
                        o_next.year  = (i_cur.year >= YEAR_MAX) ? '0 : i_cur.year + 14'd1;
                    end else begin
                        o_next.month = i_cur.month + 4'd1;
                    end
                end else begin
                    o_next.day = i_cur.day + 5'd1;
                end
            end
            OP_PREV_DAY: begin
                if (i_cur.day <= 5'd1) begin
                    if (i_cur.month <= MONTH_JAN) begin
                        // December always has 31 days, whatever the year.
                        o_next.month = MONTH_DEC;
                        o_next.year  = (i_cur.year == '0) ? YEAR_MAX : i_cur.year - 14'd1;
                        o_next.day   = DAYS_31;
                    end else begin
                        o_next.month = w_prev_month;
                        o_next.day   = w_prev_len;
                    end
                end else begin
                    o_next.day = i_cur.day - 5'd1;
                end
            end
            default: begin
                o_next   = i_cur;
                o_status = 1'b0;
            end
        endcase
    end

endmodule

/* bench/tb_calendar_date_counter.sv */
// Testbench for calendar_date_counter: directed and random command beats with
// a scoreboard that keeps its own copy of the date and checks every result.
// Depends on caldc_pkg, caldc_if and the calendar_date_counter RTL.
module tb_calendar_date_counter;
    import caldc_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    // Codes the block does not define; they must leave the date alone.
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        t_date date;
        logic  status;
    } t_date_result;

    class date_tracker;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        t_date_result       pending_dates[$];
        int                 mismatches;

        function new();
            day        = RESET_DAY;
            month      = RESET_MONTH;
            year       = RESET_YEAR;
            mismatches = 0;
        endfunction

        static function bit leap_year(int y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        static function int days_in_month(int m, int y);
            int len;
            if (m == int'(MONTH_FEB)) begin
                len = leap_year(y) ? 29 : 28;
            end else if (m == int'(MONTH_APR) || m == int'(MONTH_JUN) ||
                         m == int'(MONTH_SEP) || m == int'(MONTH_NOV)) begin
                len = 30;
            end else begin
                len = 31;
            end
            return len;
        endfunction

        static function bit valid_date(int d, int m, int y);
            if (m < int'(MONTH_JAN) || m > int'(MONTH_DEC)) return 1'b0;
            if (y > int'(YEAR_MAX)) return 1'b0;
            if (d < 1) return 1'b0;
            return d <= days_in_month(m, y);
        endfunction

        function int pending();
            return pending_dates.size();
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX) $display("%0t: %s", $realtime, what);
        endfunction

        // Applies one accepted command beat to the tracked date and queues the
        // result the block must return for it.
        function void take_command(logic [2:0] op, logic [DAY_W-1:0] d,
                                   logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
            int           nd;
            int           nm;
            int           ny;
            t_date_result res;
            nd = int'(day);
            nm = int'(month);
            ny = int'(year);
            res.status = 1'b0;
            case (op)
                OP_LOAD: begin
                    nd = int'(d);
                    nm = int'(m);
                    ny = int'(y);
                end
                OP_SET_DAY:  nd = int'(d);
                OP_SET_MON:  nm = int'(m);
                OP_SET_YEAR: ny = int'(y);
                OP_NEXT_DAY: begin
                    nd++;
                    if (nd > days_in_month(nm, ny)) begin
                        nd = 1;
                        nm++;
                        if (nm > int'(MONTH_DEC)) begin
                            nm = int'(MONTH_JAN);
                            ny = (ny >= int'(YEAR_MAX)) ? 0 : ny + 1;
                        end
                    end
                end
                OP_PREV_DAY: begin
                    if (nd <= 1) begin
                        if (nm <= int'(MONTH_JAN)) begin
                            nm = int'(MONTH_DEC);
                            ny = (ny == 0) ? int'(YEAR_MAX) : ny - 1;
                        end else begin
                            nm--;
                        end
                        nd = days_in_month(nm, ny);
                    end else begin
                        nd--;
                    end
                end
                default: ;
            endcase
            if (op <= OP_SET_YEAR && !valid_date(nd, nm, ny)) begin
                res.status = 1'b1;
            end else begin
                day   = DAY_W'(nd);
                month = MONTH_W'(nm);
                year  = YEAR_W'(ny);
            end
            res.date.day   = day;
            res.date.month = month;
            res.date.year  = year;
            pending_dates.push_back(res);
        endfunction

        function void check_result(t_date_result got);
            t_date_result want;
            if (pending_dates.size() == 0) begin
                note_mismatch($sformatf("result beat %0d/%0d/%0d status %0d with no command pending",
                                        got.date.day, got.date.month, got.date.year, got.status));
                return;
            end
            want = pending_dates.pop_front();
            if (got.date.day !== want.date.day || got.date.month !== want.date.month ||
                got.date.year !== want.date.year || got.status !== want.status) begin
                note_mismatch($sformatf("expected %0d/%0d/%0d status %0d, got %0d/%0d/%0d status %0d",
                                        want.date.day, want.date.month, want.date.year,
                                        want.status, got.date.day, got.date.month,
                                        got.date.year, got.status));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    caldc_in_if  cmd_ch ();
    caldc_out_if res_ch ();

    calendar_date_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    date_tracker book;
    int          burst_left;
    bit          sender_idle;
    int          cycle_count;

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Both channels are watched at the rising edge, where the block samples too.
    always @(posedge i_clk) begin
        t_date_result got;
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                book.take_command(cmd_ch.operation, cmd_ch.new_day, cmd_ch.new_month,
                                  cmd_ch.new_year);
            end
            if (res_ch.valid && res_ch.ready) begin
                got.date.day   = res_ch.day_now;
                got.date.month = res_ch.month_now;
                got.date.year  = res_ch.year_now;
                got.status     = res_ch.status;
                book.check_result(got);
            end
        end
    end

    // Result side: stretches of steady, random, periodic and heavy stalling.
    initial begin
        int mode;
        int stretch_left;
        int phase;
        stretch_left = 0;
        phase        = 0;
        mode         = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stretch_left == 0) begin
                mode         = $urandom_range(0, 3);
                stretch_left = $urandom_range(10, 60);
                phase        = 0;
            end
            stretch_left--;
            case (mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 1) == 1);
                2:       res_ch.ready <= (phase % 4 != 3);
                default: res_ch.ready <= (phase % 7 < 2);
            endcase
            phase++;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL calendar_date_counter");
        $finish;
    end

    // Presents one command beat at a falling edge and holds it until taken.
    task automatic send_command(input logic [2:0] op, input logic [DAY_W-1:0] d,
                                input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y);
        sender_idle         = 1'b0;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.operation   <= op;
        cmd_ch.new_day     <= d;
        cmd_ch.new_month   <= m;
        cmd_ch.new_year    <= y;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        @(negedge i_clk);
    endtask

    // Sender runs in bursts; a finished burst is followed by a short gap.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 12);
            gap          = $urandom_range(1, 6);
            sender_idle  = 1'b1;
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic [YEAR_W-1:0] pick_year();
        logic [YEAR_W-1:0] y;
        case ($urandom_range(0, 9))
            0:       y = 14'd0;
            1:       y = 14'd4;
            2:       y = 14'd100;
            3:       y = 14'd1900;
            4:       y = 14'd2000;
            5:       y = 14'd2100;
            6:       y = 14'd2400;
            7:       y = 14'd9996;
            8:       y = YEAR_MAX;
            default: y = YEAR_W'($urandom_range(0, 9999));
        endcase
        return y;
    endfunction

    // Mostly well-formed loads and day steps so that walks cross month and
    // year ends; the rest are raw loads (mostly rejected), field sets and spare codes.
    task automatic pick_command(output logic [2:0] op, output logic [DAY_W-1:0] d,
                                output logic [MONTH_W-1:0] m, output logic [YEAR_W-1:0] y);
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        op  = OP_NEXT_DAY;
        d   = DAY_W'($urandom);
        m   = MONTH_W'($urandom);
        y   = YEAR_W'($urandom);
        if (sel < 30) begin
            op = OP_NEXT_DAY;
        end else if (sel < 50) begin
            op = OP_PREV_DAY;
        end else if (sel < 62) begin
            op  = OP_LOAD;
            m   = MONTH_W'($urandom_range(1, 12));
            y   = pick_year();
            len = date_tracker::days_in_month(int'(m), int'(y));
            case ($urandom_range(0, 3))
                0:       d = DAY_W'(len);
                1:       d = 5'd1;
                2:       d = DAY_W'(len - 1);
                default: d = DAY_W'($urandom_range(1, len));
            endcase
        end else if (sel < 70) begin
            op = OP_LOAD;
        end else if (sel < 78) begin
            op = OP_SET_DAY;
            d  = DAY_W'($urandom_range(0, 31));
        end else if (sel < 86) begin
            op = OP_SET_MON;
            m  = MONTH_W'($urandom_range(0, 15));
        end else if (sel < 94) begin
            op = OP_SET_YEAR;
            if ($urandom_range(0, 5) != 0) y = pick_year();
        end else if (sel < 97) begin
            op = OP_LOAD;
            case ($urandom_range(0, 2))
                0: begin
                    d = 5'd31;
                    m = MONTH_DEC;
                    y = YEAR_MAX;
                end
                1: begin
                    d = 5'd1;
                    m = MONTH_JAN;
                    y = '0;
                end
                default: begin
                    y = pick_year();
                    m = MONTH_FEB;
                    d = DAY_W'(date_tracker::days_in_month(int'(MONTH_FEB), int'(y)));
                end
            endcase
        end else begin
            op = ($urandom_range(0, 1) == 1) ? OP_SPARE_A : OP_SPARE_B;
        end
    endtask

    task automatic directed_commands();
        // Year wrap in both directions.
        send_command(OP_LOAD, 5'd31, MONTH_DEC, YEAR_MAX);    pace_sender();
        send_command(OP_NEXT_DAY, 5'd0, 4'd0, 14'd0);         pace_sender();
        send_command(OP_PREV_DAY, 5'd31, 4'd15, 14'h3FFF);    pace_sender();
        // Rejected loads: day zero, bad months, year too large, day past month end.
        send_command(OP_LOAD, 5'd0, MONTH_JAN, 14'd2000);     pace_sender();
        send_command(OP_LOAD, 5'd1, 4'd0, 14'd2000);          pace_sender();
        send_command(OP_LOAD, 5'd1, 4'd13, 14'd2000);         pace_sender();
        send_command(OP_LOAD, 5'd31, 4'd15, 14'h3FFF);        pace_sender();
        send_command(OP_LOAD, 5'd1, MONTH_JAN, 14'd10000);    pace_sender();
        send_command(OP_LOAD, 5'd31, MONTH_APR, 14'd2021);    pace_sender();
        send_command(OP_LOAD, 5'd29, MONTH_FEB, 14'd1900);    pace_sender();
        // Year zero is a leap year.
        send_command(OP_LOAD, 5'd29, MONTH_FEB, 14'd0);       pace_sender();
        // Changing the year under February 29 needs a leap target.
        send_command(OP_SET_YEAR, 5'd0, 4'd0, 14'd1900);      pace_sender();
        send_command(OP_SET_YEAR, 5'd0, 4'd0, 14'd2004);      pace_sender();
        send_command(OP_NEXT_DAY, 5'd0, 4'd0, 14'd0);         pace_sender();
        send_command(OP_PREV_DAY, 5'd0, 4'd0, 14'd0);         pace_sender();
        send_command(OP_SET_DAY, 5'd30, 4'd0, 14'd0);         pace_sender();
        send_command(OP_SET_DAY, 5'd0, 4'd0, 14'd0);          pace_sender();
        send_command(OP_SET_MON, 5'd0, MONTH_JAN, 14'd0);     pace_sender();
        send_command(OP_SET_MON, 5'd0, 4'd0, 14'd0);          pace_sender();
        send_command(OP_SET_DAY, 5'd31, 4'd0, 14'd0);         pace_sender();
        send_command(OP_SET_MON, 5'd31, MONTH_APR, 14'd0);    pace_sender();
        // Century year that is not a leap year.
        send_command(OP_LOAD, 5'd28, MONTH_FEB, 14'd2100);    pace_sender();
        send_command(OP_NEXT_DAY, 5'd0, 4'd0, 14'd0);         pace_sender();
        send_command(OP_LOAD, 5'd1, MONTH_JAN, 14'd0);        pace_sender();
        send_command(OP_PREV_DAY, 5'd0, 4'd0, 14'd0);         pace_sender();
        send_command(OP_SPARE_A, 5'd31, 4'd15, 14'h3FFF);     pace_sender();
        send_command(OP_SPARE_B, 5'd0, 4'd0, 14'd0);          pace_sender();
    endtask

    initial begin
        logic [2:0]         op;
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        book             = new();
        burst_left       = 0;
        sender_idle      = 1'b1;
        i_rst_n          = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = '0;
        cmd_ch.new_day   = '0;
        cmd_ch.new_month = '0;
        cmd_ch.new_year  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_commands();
        repeat (RANDOM_ITEMS) begin
            pick_command(op, d, m, y);
            send_command(op, d, m, y);
            pace_sender();
        end
        if (!sender_idle) cmd_ch.valid <= 1'b0;

        while (book.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("PASS calendar_date_counter");
        end else begin
            $display("FAIL calendar_date_counter");
        end
        $finish;
    end

endmodule
